// ----- design/ffha_pkg.sv -----
// Shared types, constants and codes of the first-fit heap allocator.
package ffha_pkg;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int SEG_W  = 25;
  localparam int PAD_W  = ADDR_W - SEG_W;

  // Table depth default and header sizes
  localparam int MAX_SEGMENTS_DEF  = 64;
  localparam int NODE_HEADER_BYTES = 32;
  localparam int LIST_HEADER_BYTES = 32;

  localparam logic [SEG_W-1:0] NODE_HDR   = SEG_W'(NODE_HEADER_BYTES);
  localparam logic [SEG_W-1:0] NODE_HDR2  = SEG_W'(2 * NODE_HEADER_BYTES);
  localparam logic [SEG_W-1:0] HDR_BASE   = SEG_W'(LIST_HEADER_BYTES + NODE_HEADER_BYTES);
  localparam logic [SEG_W-1:0] HEAP_MIN   = SEG_W'(128);
  localparam logic [SEG_W-1:0] HEAP_MAX   = SEG_W'(16777216);
  localparam logic [SEG_W-1:0] HEAP_RESET = SEG_W'(1048576);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Shared adder operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SEG_W-1:0]  alloc_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] block_address;
    logic [SEG_W-1:0]  used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [SEG_W-1:0] offset;
    logic [SEG_W-1:0] size;
    logic             busy;
  } seg_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

// ----- design/ffha_alu.sv -----
// Shared 32-bit add/subtract unit with carry or borrow out.
module ffha_alu (
  input  ffha_pkg::alu_req_t req,
  output ffha_pkg::alu_rsp_t rsp
);
  import ffha_pkg::*;

  logic [ADDR_W:0] wide;

  // Add or subtract one bit wider to expose carry or borrow
  always_comb begin
    case (req.op)
      ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
      default: wide = {1'b0, req.a} + {1'b0, req.b};
    endcase
  end

  assign rsp.sum   = wide[ADDR_W-1:0];
  assign rsp.carry = wide[ADDR_W];

endmodule

// ----- design/ffha_seg_ram.sv -----
// Segment table memory: one write port, one registered read port.
module ffha_seg_ram #(
  parameter int DEPTH = ffha_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ffha_pkg::seg_t           wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ffha_pkg::seg_t           rdata
);
  import ffha_pkg::*;

  seg_t mem [DEPTH];

  // Write and read the table
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/first_fit_heap_allocator_core.sv -----
// Top level of the first-fit heap allocator with coalescing of free neighbors.
//
// Takes one allocate or free item at a time: an item is accepted when start is high and
// busy is low, and its result appears on out_rsp for exactly one cycle with out_valid
// high; the receiver cannot stall it. The segment table lives in a single-port-write,
// single-port-read memory visited one entry per cycle, and all size and address
// arithmetic goes through one shared adder. An allocate scans for the first fitting
// segment; when it is split, the remainder's offset and size are computed and the later
// entries move up one slot to make room for it. A free scans for its block and, when it
// merges with a neighbor, sums the merged sizes and moves the later entries down; a free
// of address zero answers at once. A refused item answers as soon as its scan ends: at a
// zero-size or already-free segment, or past the last entry. After reset, and after each
// heap_bytes write, the table is rebuilt in the S_INIT state, during which busy is high.
module first_fit_heap_allocator_core #(
  parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ffha_pkg::req_t                in_req,
  output logic                          out_valid,
  output ffha_pkg::rsp_t                out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffha_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ffha_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  // Sequencer states
  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_SCAN   = 5'd2;
  localparam logic [4:0] S_F_NEXT = 5'd3;
  localparam logic [4:0] S_F_SUB  = 5'd4;
  localparam logic [4:0] S_F_ACC1 = 5'd5;
  localparam logic [4:0] S_F_ACC2 = 5'd6;
  localparam logic [4:0] S_F_ACC3 = 5'd7;
  localparam logic [4:0] S_F_USED = 5'd8;
  localparam logic [4:0] S_DN     = 5'd9;
  localparam logic [4:0] S_A_OFF1 = 5'd10;
  localparam logic [4:0] S_A_OFF2 = 5'd11;
  localparam logic [4:0] S_A_SIZE = 5'd12;
  localparam logic [4:0] S_A_HDR  = 5'd13;
  localparam logic [4:0] S_UP     = 5'd14;
  localparam logic [4:0] S_A_INS  = 5'd15;
  localparam logic [4:0] S_A_USED = 5'd16;
  localparam logic [4:0] S_A_ADDR = 5'd17;

  logic [4:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SEG_W-1:0]  used_r, used_nxt;
  logic [ADDR_W-1:0] base_r;
  logic [SEG_W-1:0]  hbytes_r;
  req_t              req_r, req_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  seg_t              cur_r, cur_nxt;
  seg_t              prev_r, prev_nxt;
  seg_t              next_r, next_nxt;
  logic              pf_r, pf_nxt;
  logic              nf_r, nf_nxt;
  logic              split_r, split_nxt;
  logic              dist2_r, dist2_nxt;
  logic [SEG_W-1:0]  acc_r, acc_nxt;
  logic [SEG_W-1:0]  tmp_r, tmp_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;

  // Index arithmetic
  logic [CW-1:0] idx_inc, k_inc, k_inc2, k_dec, cnt_dec, move_len;
  logic [CW-1:0] ptr_inc, ptr_dec, ptr_dec2, ptr_dst, src;
  logic [SEG_W-1:0] hdr, size_k;
  logic             both;

  // Table and adder ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  seg_t          ram_wdata, ram_rdata;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  // Finish strobe of the sequencer
  logic              fin, fin_ok;
  logic [ADDR_W-1:0] fin_addr;

  // Configuration decode
  logic             cfg_wr;
  logic [SEG_W-1:0] wr_bytes, hb_clamped;

  ffha_seg_ram #(
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffha_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  // Clamp a heap size write into its legal range
  assign wr_bytes   = pwdata[SEG_W-1:0];
  assign hb_clamped = (wr_bytes < HEAP_MIN) ? HEAP_MIN :
                      (wr_bytes > HEAP_MAX) ? HEAP_MAX : wr_bytes;

  // Return register contents
  always_comb begin
    case (paddr[CFG_AW-1])
      REG_HEAP_BASE:  prdata = base_r;
      REG_HEAP_BYTES: prdata = {{PAD_W{1'b0}}, hbytes_r};
      default:        prdata = '0;
    endcase
  end

  // Derive neighbor indexes and merge parameters
  always_comb begin
    idx_inc  = idx_r + ONE;
    k_inc    = k_r + ONE;
    k_inc2   = k_r + TWO;
    k_dec    = k_r - ONE;
    cnt_dec  = cnt_r - ONE;
    move_len = dist2_r ? TWO : ONE;
    ptr_inc  = ptr_r + ONE;
    ptr_dec  = ptr_r - ONE;
    ptr_dec2 = ptr_r - TWO;
    ptr_dst  = ptr_r - move_len;
    both     = pf_r && nf_r;
    src      = (pf_r && !nf_r) ? k_inc : k_inc2;
    hdr      = both ? NODE_HDR2 : NODE_HDR;
    size_k   = split_r ? req_r.alloc_bytes : cur_r.size;
  end

  // Sequence one item through the table and the shared adder
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    pf_nxt        = pf_r;
    nf_nxt        = nf_r;
    split_nxt     = split_r;
    dist2_nxt     = dist2_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    alu_req.op    = ALU_ADD;
    alu_req.a     = '0;
    alu_req.b     = '0;
    fin           = 1'b0;
    fin_ok        = 1'b0;
    fin_addr      = '0;

    case (state_r)
      S_INIT: begin
        // Rebuild the table as one free segment
        alu_req.op       = ALU_SUB;
        alu_req.a        = {{PAD_W{1'b0}}, hbytes_r};
        alu_req.b        = {{PAD_W{1'b0}}, HDR_BASE};
        ram_we           = 1'b1;
        ram_waddr        = '0;
        ram_wdata.offset = HDR_BASE;
        ram_wdata.size   = alu_rsp.sum[SEG_W-1:0];
        ram_wdata.busy   = 1'b0;
        cnt_nxt          = ONE;
        used_nxt         = HDR_BASE;
        state_nxt        = S_IDLE;
      end

      S_IDLE: begin
        // Take an item and fetch the first entry
        if (start) begin
          req_nxt   = in_req;
          idx_nxt   = '0;
          ram_raddr = '0;
          if (in_req.req_type == REQ_FREE && in_req.free_address == '0) begin
            fin = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Examine one entry a cycle, fetching the next one meanwhile
        ram_raddr = idx_inc[AW-1:0];
        if (idx_r == cnt_r) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else if (req_r.req_type == REQ_ALLOC) begin
          alu_req.op = ALU_SUB;
          alu_req.a  = {{PAD_W{1'b0}}, ram_rdata.size};
          alu_req.b  = {{PAD_W{1'b0}}, req_r.alloc_bytes};
          if (ram_rdata.size == '0) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end else if (ram_rdata.busy || alu_rsp.carry) begin
            idx_nxt = idx_inc;
          end else begin
            k_nxt   = idx_r;
            cur_nxt = ram_rdata;
            acc_nxt = alu_rsp.sum[SEG_W-1:0];
            if (alu_rsp.sum[SEG_W-1:0] > NODE_HDR && cnt_r < MAX_CNT) begin
              split_nxt = 1'b1;
              state_nxt = S_A_OFF1;
            end else begin
              split_nxt = 1'b0;
              state_nxt = S_A_USED;
            end
          end
        end else begin
          alu_req.op = ALU_ADD;
          alu_req.a  = base_r;
          alu_req.b  = {{PAD_W{1'b0}}, ram_rdata.offset};
          if (alu_rsp.sum == req_r.free_address) begin
            if (!ram_rdata.busy) begin
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              k_nxt   = idx_r;
              cur_nxt = ram_rdata;
              pf_nxt  = (idx_r != '0) && !prev_r.busy;
              if (idx_inc < cnt_r) begin
                state_nxt = S_F_NEXT;
              end else begin
                nf_nxt    = 1'b0;
                state_nxt = S_F_SUB;
              end
            end
          end else begin
            prev_nxt = ram_rdata;
            idx_nxt  = idx_inc;
          end
        end
      end

      S_F_NEXT: begin
        // Capture the right neighbor
        next_nxt  = ram_rdata;
        nf_nxt    = !ram_rdata.busy;
        state_nxt = S_F_SUB;
      end

      S_F_SUB: begin
        // Drop the freed bytes from the used count
        alu_req.op = ALU_SUB;
        alu_req.a  = {{PAD_W{1'b0}}, used_r};
        alu_req.b  = {{PAD_W{1'b0}}, cur_r.size};
        used_nxt   = alu_rsp.sum[SEG_W-1:0];
        if (!pf_r && !nf_r) begin
          ram_we           = 1'b1;
          ram_waddr        = k_r[AW-1:0];
          ram_wdata.offset = cur_r.offset;
          ram_wdata.size   = cur_r.size;
          ram_wdata.busy   = 1'b0;
          fin              = 1'b1;
          fin_ok           = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          state_nxt = S_F_ACC1;
        end
      end

      S_F_ACC1: begin
        // Sum the first two sizes of the merge
        alu_req.op = ALU_ADD;
        alu_req.a  = {{PAD_W{1'b0}}, (pf_r ? prev_r.size : cur_r.size)};
        alu_req.b  = {{PAD_W{1'b0}}, (pf_r ? cur_r.size : next_r.size)};
        acc_nxt    = alu_rsp.sum[SEG_W-1:0];
        state_nxt  = both ? S_F_ACC2 : S_F_ACC3;
      end

      S_F_ACC2: begin
        // Add the right neighbor of a three-way merge
        alu_req.op = ALU_ADD;
        alu_req.a  = {{PAD_W{1'b0}}, acc_r};
        alu_req.b  = {{PAD_W{1'b0}}, next_r.size};
        acc_nxt    = alu_rsp.sum[SEG_W-1:0];
        state_nxt  = S_F_ACC3;
      end

      S_F_ACC3: begin
        // Reclaim the headers of the merged segments
        alu_req.op = ALU_ADD;
        alu_req.a  = {{PAD_W{1'b0}}, acc_r};
        alu_req.b  = {{PAD_W{1'b0}}, hdr};
        acc_nxt    = alu_rsp.sum[SEG_W-1:0];
        state_nxt  = S_F_USED;
      end

      S_F_USED: begin
        // Write the merged segment and start closing the gap
        alu_req.op       = ALU_SUB;
        alu_req.a        = {{PAD_W{1'b0}}, used_r};
        alu_req.b        = {{PAD_W{1'b0}}, hdr};
        used_nxt         = alu_rsp.sum[SEG_W-1:0];
        ram_we           = 1'b1;
        ram_waddr        = pf_r ? k_dec[AW-1:0] : k_r[AW-1:0];
        ram_wdata.offset = pf_r ? prev_r.offset : cur_r.offset;
        ram_wdata.size   = acc_r;
        ram_wdata.busy   = 1'b0;
        dist2_nxt        = both;
        if (src < cnt_r) begin
          ram_raddr = src[AW-1:0];
          ptr_nxt   = src;
          state_nxt = S_DN;
        end else begin
          cnt_nxt   = cnt_r - (both ? TWO : ONE);
          fin       = 1'b1;
          fin_ok    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DN: begin
        // Move one entry down per cycle
        ram_we    = 1'b1;
        ram_waddr = ptr_dst[AW-1:0];
        ram_wdata = ram_rdata;
        if (ptr_inc == cnt_r) begin
          cnt_nxt   = cnt_r - move_len;
          fin       = 1'b1;
          fin_ok    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = ptr_inc[AW-1:0];
          ptr_nxt   = ptr_inc;
        end
      end

      S_A_OFF1: begin
        // Offset of the split remainder, first part
        alu_req.op = ALU_ADD;
        alu_req.a  = {{PAD_W{1'b0}}, cur_r.offset};
        alu_req.b  = {{PAD_W{1'b0}}, req_r.alloc_bytes};
        tmp_nxt    = alu_rsp.sum[SEG_W-1:0];
        state_nxt  = S_A_OFF2;
      end

      S_A_OFF2: begin
        // Step over the new node header
        alu_req.op = ALU_ADD;
        alu_req.a  = {{PAD_W{1'b0}}, tmp_r};
        alu_req.b  = {{PAD_W{1'b0}}, NODE_HDR};
        tmp_nxt    = alu_rsp.sum[SEG_W-1:0];
        state_nxt  = S_A_SIZE;
      end

      S_A_SIZE: begin
        // Size of the split remainder
        alu_req.op = ALU_SUB;
        alu_req.a  = {{PAD_W{1'b0}}, acc_r};
        alu_req.b  = {{PAD_W{1'b0}}, NODE_HDR};
        acc_nxt    = alu_rsp.sum[SEG_W-1:0];
        state_nxt  = S_A_HDR;
      end

      S_A_HDR: begin
        // Count the new header and start opening a slot
        alu_req.op = ALU_ADD;
        alu_req.a  = {{PAD_W{1'b0}}, used_r};
        alu_req.b  = {{PAD_W{1'b0}}, NODE_HDR};
        used_nxt   = alu_rsp.sum[SEG_W-1:0];
        if (k_inc < cnt_r) begin
          ram_raddr = cnt_dec[AW-1:0];
          ptr_nxt   = cnt_r;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_A_INS;
        end
      end

      S_UP: begin
        // Move one entry up per cycle, top first
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = ram_rdata;
        if (ptr_r == k_inc2) begin
          state_nxt = S_A_INS;
        end else begin
          ram_raddr = ptr_dec2[AW-1:0];
          ptr_nxt   = ptr_dec;
        end
      end

      S_A_INS: begin
        // Insert the free remainder after the block
        ram_we           = 1'b1;
        ram_waddr        = k_inc[AW-1:0];
        ram_wdata.offset = tmp_r;
        ram_wdata.size   = acc_r;
        ram_wdata.busy   = 1'b0;
        cnt_nxt          = cnt_r + ONE;
        state_nxt        = S_A_USED;
      end

      S_A_USED: begin
        // Mark the block busy and count its bytes
        alu_req.op       = ALU_ADD;
        alu_req.a        = {{PAD_W{1'b0}}, used_r};
        alu_req.b        = {{PAD_W{1'b0}}, size_k};
        used_nxt         = alu_rsp.sum[SEG_W-1:0];
        ram_we           = 1'b1;
        ram_waddr        = k_r[AW-1:0];
        ram_wdata.offset = cur_r.offset;
        ram_wdata.size   = size_k;
        ram_wdata.busy   = 1'b1;
        state_nxt        = S_A_ADDR;
      end

      S_A_ADDR: begin
        // Report the payload address
        alu_req.op = ALU_ADD;
        alu_req.a  = base_r;
        alu_req.b  = {{PAD_W{1'b0}}, cur_r.offset};
        fin        = 1'b1;
        fin_ok     = 1'b1;
        fin_addr   = alu_rsp.sum;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // A heap size write rebuilds the table
    if (cfg_wr && paddr[CFG_AW-1] == REG_HEAP_BYTES) begin
      state_nxt = S_INIT;
    end

    // Form the result item
    out_valid_nxt             = fin;
    out_rsp_nxt               = out_rsp_r;
    if (fin) begin
      out_rsp_nxt.ok            = fin_ok;
      out_rsp_nxt.block_address = fin_addr;
      out_rsp_nxt.used_bytes    = used_nxt;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= ONE;
      used_r      <= HDR_BASE;
      base_r      <= '0;
      hbytes_r    <= HEAP_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      k_r         <= '0;
      ptr_r       <= '0;
      pf_r        <= 1'b0;
      nf_r        <= 1'b0;
      split_r     <= 1'b0;
      dist2_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      ptr_r       <= ptr_nxt;
      pf_r        <= pf_nxt;
      nf_r        <= nf_nxt;
      split_r     <= split_nxt;
      dist2_r     <= dist2_nxt;
      if (cfg_wr) begin
        case (paddr[CFG_AW-1])
          REG_HEAP_BASE:  base_r   <= pwdata;
          REG_HEAP_BYTES: hbytes_r <= hb_clamped;
          default:        base_r   <= base_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    next_r    <= next_nxt;
    acc_r     <= acc_nxt;
    tmp_r     <= tmp_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Segment count stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= MAX_CNT))
    else $error("segment count out of range");

  // An accepted item other than a null free keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_req.req_type == REQ_FREE && in_req.free_address == '0))
    |=> busy)
    else $error("accepted item did not occupy the sequencer");

  // Opening a slot never moves the chosen entry itself
  a_up_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (ptr_r > k_inc))
    else $error("shift up pointer passed the split entry");

  // Closing a gap only reads live entries
  a_dn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN) |-> (ptr_r < cnt_r))
    else $error("shift down pointer beyond table end");

  // A reported address implies success
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.block_address != '0) |-> out_rsp.ok)
    else $error("address reported on a failed item");

endmodule

// ----- tb/first_fit_heap_allocator_core_tb.sv -----
// Self-checking testbench for the first-fit heap allocator core.
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_tb;
  import ffha_pkg::*;

  localparam int SEG_SLOTS   = MAX_SEGMENTS_DEF;
  localparam int PHASES      = 8;
  localparam int HALF_ITEMS  = 120;
  localparam int DIRECTED    = 25;
  localparam int SETTLE      = 200;
  localparam int STALL_LIMIT = 4000;

  // Heap table tracker: mirrors the segment table and holds the replies still owed
  class heap_ledger;
    logic [ADDR_W-1:0] base;
    logic [SEG_W-1:0]  bytes_total;
    logic [SEG_W-1:0]  seg_off [SEG_SLOTS];
    logic [SEG_W-1:0]  seg_len [SEG_SLOTS];
    bit                seg_used [SEG_SLOTS];
    int                nseg;
    logic [SEG_W-1:0]  used;
    rsp_t              pending_replies [$];
    int                errors;

    function new();
      base        = '0;
      bytes_total = HEAP_RESET;
      errors      = 0;
      rebuild();
    endfunction

    // Restart the table as one free segment after the list and node headers
    function void rebuild();
      for (int i = 0; i < SEG_SLOTS; i++) begin
        seg_off[i]  = '0;
        seg_len[i]  = '0;
        seg_used[i] = 1'b0;
      end
      seg_off[0] = HDR_BASE;
      seg_len[0] = bytes_total - HDR_BASE;
      nseg       = 1;
      used       = HDR_BASE;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      logic [SEG_W-1:0] v;
      if (idx == REG_HEAP_BASE) begin
        base = data;
      end else begin
        // Clamp the 25-bit value into the legal heap range
        v = data[SEG_W-1:0];
        if (v < HEAP_MIN) v = HEAP_MIN;
        if (v > HEAP_MAX) v = HEAP_MAX;
        bytes_total = v;
        rebuild();
      end
    endfunction

    function void drop_entry(int k);
      if (k >= nseg) return;
      for (int j = k; j < nseg - 1; j++) begin
        seg_off[j]  = seg_off[j+1];
        seg_len[j]  = seg_len[j+1];
        seg_used[j] = seg_used[j+1];
      end
      nseg--;
    endfunction

    function void add_after(int k, logic [SEG_W-1:0] off, logic [SEG_W-1:0] len);
      if (nseg >= SEG_SLOTS || k >= nseg) return;
      for (int j = nseg; j > k + 1; j--) begin
        seg_off[j]  = seg_off[j-1];
        seg_len[j]  = seg_len[j-1];
        seg_used[j] = seg_used[j-1];
      end
      seg_off[k+1]  = off;
      seg_len[k+1]  = len;
      seg_used[k+1] = 1'b0;
      nseg++;
    endfunction

    // First fit: stop at a zero-size segment, split when the surplus allows
    function bit place_block(logic [SEG_W-1:0] req, output logic [ADDR_W-1:0] addr);
      logic [SEG_W-1:0] surplus;
      addr = '0;
      for (int i = 0; i < nseg; i++) begin
        if (seg_len[i] == '0) return 1'b0;
        if (seg_used[i] || seg_len[i] < req) continue;
        if (seg_len[i] > req) begin
          surplus = seg_len[i] - req;
          if (surplus > NODE_HDR && nseg < SEG_SLOTS) begin
            add_after(i, seg_off[i] + req + NODE_HDR, surplus - NODE_HDR);
            seg_len[i] = req;
            used       = used + NODE_HDR;
          end
        end
        seg_used[i] = 1'b1;
        used        = used + seg_len[i];
        addr        = base + {{PAD_W{1'b0}}, seg_off[i]};
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Release a busy segment and merge it with free neighbors
    function bit release_block(logic [ADDR_W-1:0] a);
      int i;
      bit pf;
      bit nf;
      if (a == '0) return 1'b0;
      for (i = 0; i < nseg; i++)
        if (base + {{PAD_W{1'b0}}, seg_off[i]} == a) break;
      if (i >= nseg || !seg_used[i]) return 1'b0;
      pf = (i > 0) && !seg_used[i-1];
      nf = (i + 1 < nseg) && !seg_used[i+1];
      used = used - seg_len[i];
      if (pf && nf) begin
        seg_len[i-1] = seg_len[i-1] + seg_len[i] + seg_len[i+1] + NODE_HDR2;
        used = used - NODE_HDR2;
        drop_entry(i + 1);
        drop_entry(i);
      end else if (pf) begin
        seg_len[i-1] = seg_len[i-1] + seg_len[i] + NODE_HDR;
        used = used - NODE_HDR;
        drop_entry(i);
      end else if (nf) begin
        seg_len[i]  = seg_len[i] + seg_len[i+1] + NODE_HDR;
        seg_used[i] = 1'b0;
        used = used - NODE_HDR;
        drop_entry(i + 1);
      end else begin
        seg_used[i] = 1'b0;
      end
      return 1'b1;
    endfunction

    function void accept_request(req_t r);
      rsp_t              e;
      logic [ADDR_W-1:0] a;
      if (r.req_type == REQ_ALLOC) begin
        e.ok            = place_block(r.alloc_bytes, a);
        e.block_address = e.ok ? a : '0;
      end else begin
        e.ok            = release_block(r.free_address);
        e.block_address = '0;
      end
      e.used_bytes = used;
      pending_replies.push_back(e);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t e;
      if (pending_replies.size() == 0) begin
        $error("reply with no item outstanding: ok %0d addr %h used %0d",
               got.ok, got.block_address, got.used_bytes);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (got.ok !== e.ok) begin
        $error("ok: expected %0d, actual %0d", e.ok, got.ok);
        errors++;
      end
      if (got.block_address !== e.block_address) begin
        $error("block_address: expected %h, actual %h", e.block_address, got.block_address);
        errors++;
      end
      if (got.used_bytes !== e.used_bytes) begin
        $error("used_bytes: expected %0d, actual %0d", e.used_bytes, got.used_bytes);
        errors++;
      end
    endfunction

    function logic [ADDR_W-1:0] addr_of(int k);
      return base + {{PAD_W{1'b0}}, seg_off[k]};
    endfunction

    function logic [SEG_W-1:0] len_of(int k);
      return seg_len[k];
    endfunction

    // Pick a random segment that is busy or free, as asked
    function bit pick_segment(bit want_busy, output logic [ADDR_W-1:0] addr,
                              output logic [SEG_W-1:0] len);
      int hits [$];
      int k;
      addr = '0;
      len  = '0;
      for (int i = 0; i < nseg; i++)
        if (seg_used[i] == want_busy) hits.push_back(i);
      if (hits.size() == 0) return 1'b0;
      k    = hits[$urandom_range(0, hits.size() - 1)];
      addr = addr_of(k);
      len  = seg_len[k];
      return 1'b1;
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  req_t                in_req;
  logic                out_valid;
  rsp_t                out_rsp;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  heap_ledger ledger;
  int         idle_cycles;
  bit         burst;

  first_fit_heap_allocator_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Track accepted items, replies and register writes; count quiet cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (start && busy === 1'b0) ledger.accept_request(in_req);
      if (out_valid === 1'b1) ledger.check_reply(out_rsp);
      if ((start && busy === 1'b0) || out_valid === 1'b1 ||
          (psel && penable && pwrite && pready === 1'b1))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function req_t free_req(logic [ADDR_W-1:0] a);
    req_t r;
    r.req_type     = REQ_FREE;
    r.alloc_bytes  = SEG_W'($urandom);
    r.free_address = a;
    return r;
  endfunction

  function req_t alloc_req(logic [SEG_W-1:0] sz);
    req_t r;
    r.req_type     = REQ_ALLOC;
    r.alloc_bytes  = sz;
    r.free_address = $urandom;
    return r;
  endfunction

  // Mostly small sizes against the heap, with zero sizes, exact fits, near fits and huge requests
  function logic [SEG_W-1:0] alloc_size();
    int unsigned       pick;
    int unsigned       cap;
    logic [ADDR_W-1:0] a;
    logic [SEG_W-1:0]  len;
    pick = $urandom_range(0, 99);
    cap  = 32'(ledger.bytes_total) >> $urandom_range(4, 8);
    if (cap == 0) cap = 1;
    if (pick < 3) return '0;
    if (pick < 23 && ledger.pick_segment(1'b0, a, len)) begin
      if (pick < 13 || len < 41) return len;
      return len - SEG_W'($urandom_range(0, 40));
    end
    if (pick < 27) return SEG_W'($urandom);
    if (pick < 30) return pick[0] ? HEAP_MAX : '1;
    return SEG_W'($urandom_range(1, cap));
  endfunction

  function req_t random_request();
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    logic [SEG_W-1:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 4) return free_req('0);
    if (pick < 6) return free_req($urandom);
    if (pick < 9) begin
      // Near miss: just past the start of a live block
      if (ledger.pick_segment(1'b1, a, len))
        return free_req(a + ADDR_W'($urandom_range(1, 31)));
      return free_req($urandom);
    end
    if (pick < 15 && ledger.pick_segment(1'b0, a, len)) return free_req(a);
    if (pick < 50 && ledger.pick_segment(1'b1, a, len)) return free_req(a);
    return alloc_req(alloc_size());
  endfunction

  // Opening sequence on the reset heap: refusals, zero-size block, splits, all merges
  function req_t directed_request(int n);
    case (n)
      0:       return free_req('0);
      1:       return free_req(32'hDEAD_BEEF);
      2:       return free_req(ledger.addr_of(0));
      3:       return alloc_req('1);
      4:       return alloc_req(HEAP_MAX);
      5:       return alloc_req('0);
      6:       return alloc_req(SEG_W'(10));
      7:       return free_req(ledger.addr_of(0));
      8, 9, 10, 15, 16:
               return alloc_req(SEG_W'(100));
      11, 12, 18:
               return free_req(ledger.addr_of(0));
      13:      return free_req(ledger.addr_of(2));
      14, 19, 22:
               return free_req(ledger.addr_of(1));
      17:      return alloc_req(ledger.len_of(2));
      20:      return alloc_req(SEG_W'(190));
      21:      return alloc_req(SEG_W'(10));
      default: return alloc_req(SEG_W'(1));
    endcase
  endfunction

  function int draw_gap();
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Wait for the next falling edge; hold start low for the drawn gap
  task automatic wait_slot(input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Present an item and hold it until the core takes it
  task automatic drive_item(input req_t r);
    in_req = r;
    start  = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic run_random(input int count);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      wait_slot(draw_gap());
      drive_item(random_request());
    end
  endtask

  // Drop start and drain every outstanding reply
  task automatic quiesce();
    @(negedge clk);
    start = 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    ledger.write_reg(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function logic [31:0] heap_bytes_for(int p);
    case (p)
      0:       return 32'd128;
      1:       return 32'd2048;
      2:       return $urandom_range(512, 8192);
      3:       return 32'd16777216;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'd1048576;
      6:       return $urandom_range(1024, 65536);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function logic [31:0] heap_base_for(int p);
    case (p % 4)
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0 - {{PAD_W{1'b0}}, HDR_BASE};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    ledger  = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    burst   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int n = 0; n < DIRECTED; n++) begin
      wait_slot(draw_gap());
      drive_item(directed_request(n));
    end
    quiesce();

    // Each phase: new heap size and base, traffic, move the base, more traffic
    for (int p = 0; p < PHASES; p++) begin
      cfg_write(REG_HEAP_BYTES, heap_bytes_for(p));
      cfg_write(REG_HEAP_BASE, heap_base_for(p));
      run_random(HALF_ITEMS);
      quiesce();
      cfg_write(REG_HEAP_BASE, heap_base_for(p + 1 + $urandom_range(0, 1)));
      run_random(HALF_ITEMS);
      quiesce();
    end

    repeat (SETTLE) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_replies.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
